// ===== sv/ctli_pkg.sv =====
package ctli_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_FREQ_BITS   = 32;

  localparam int LEVEL_W    = 12;
  localparam int LEN_W      = 9;
  localparam int IDX_IN_W   = 8;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [IDX_IN_W-1:0]       entry_idx_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_USE_TABLE    = 3'd0;
  localparam logic [2:0] REG_BASE_LEVEL   = 3'd1;
  localparam logic [2:0] REG_REF_CORR     = 3'd2;
  localparam logic [2:0] REG_MAX_LEVEL    = 3'd3;
  localparam logic [2:0] REG_MIN_LEVEL    = 3'd4;
  localparam logic [2:0] REG_TABLE_LENGTH = 3'd5;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam level_t MAX_LEVEL_RST    = 12'sd130;
  localparam level_t MIN_LEVEL_RST    = -12'sd1400;
  localparam len_t   TABLE_LENGTH_RST = 9'd2;

endpackage

// ===== sv/ctli_if.sv =====
interface ctli_in_if
  import ctli_pkg::*;
#(
  parameter int FREQ_BITS = DEF_FREQ_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  entry_idx_t           entry_index;
  logic [FREQ_BITS-1:0] frequency_hz;
  level_t               entry_correction;

  modport source (output valid, kind, entry_index, frequency_hz, entry_correction,
                  input ready);
  modport sink (input valid, kind, entry_index, frequency_hz, entry_correction,
                output ready);
endinterface

interface ctli_out_if
  import ctli_pkg::*;
();
  logic   valid;
  logic   ready;
  level_t level;
  logic   clamped;
  logic   out_of_table;

  modport source (output valid, level, clamped, out_of_table, input ready);
  modport sink (input valid, level, clamped, out_of_table, output ready);
endinterface

// ===== sv/calibration_table_level_interpolator.sv =====
// Load beat: accepted in S_IDLE, which the sequencer does not leave, so ready stays high.
// Query, table off: S_SUM, then the output register; S_SUM waits while the last result is unaccepted.
// Query, table on: reads the end entries (S_RD_LO, S_RD_HI), bisects the table (one memory read
// per step), then interpolates in the mul/div unit before S_SUM and the output register.
// One item at a time; a waiting result does not block the next accept.
// Sync active-low reset sets control and config registers; table is undefined until loaded.
module calibration_table_level_interpolator
  import ctli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int FREQ_BITS   = DEF_FREQ_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ctli_in_if.sink               in_ch,
  ctli_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LEN_X_W = ($clog2(TABLE_DEPTH + 1) > LEN_W) ? $clog2(TABLE_DEPTH + 1) : LEN_W;

  typedef logic signed [LEVEL_W+1:0] sum_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD_LO = 3'd1;
  localparam logic [2:0] S_RD_HI = 3'd2;
  localparam logic [2:0] S_BIS   = 3'd3;
  localparam logic [2:0] S_MID   = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;
  localparam logic [2:0] S_MDU   = 3'd6;
  localparam logic [2:0] S_SUM   = 3'd7;

  // config registers
  logic   use_table_r;
  level_t base_level_r, ref_corr_r, max_level_r, min_level_r;
  len_t   table_length_r;
  logic   cfg_wr;

  // sequencer
  logic [2:0]           state_r, state_nxt;
  logic [FREQ_BITS-1:0] f_q_r, f_q_nxt;
  logic [FREQ_BITS-1:0] f_lo_r, f_lo_nxt, f_hi_r, f_hi_nxt;
  level_t               c_lo_r, c_lo_nxt, c_hi_r, c_hi_nxt;
  level_t               corr_r, corr_nxt;
  logic [IDX_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic                 oot_r, oot_nxt;
  logic                 byp_r, byp_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  level_t out_level_r, out_level_nxt;
  logic   out_clamped_r, out_clamped_nxt;
  logic   out_oot_r, out_oot_nxt;

  // table
  logic                 tbl_wr;
  logic [IDX_W-1:0]     rd_addr;
  logic [FREQ_BITS-1:0] rd_freq;
  level_t               rd_corr;

  // mul/div unit
  logic   mdu_start, mdu_done;
  level_t mdu_q;

  logic [LEN_X_W-1:0] len_x, used_len;
  logic [IDX_W-1:0]   last_idx, mid, span;
  logic [IDX_W:0]     mid_sum;
  logic               in_acc, load_ok;

  sum_t lvl_raw, lvl_lo, lvl_fin;
  logic hit_lo, hit_hi;

  // ---------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_table_r    <= 1'b0;
      base_level_r   <= '0;
      ref_corr_r     <= '0;
      max_level_r    <= MAX_LEVEL_RST;
      min_level_r    <= MIN_LEVEL_RST;
      table_length_r <= TABLE_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_USE_TABLE:    use_table_r    <= cfg_pwdata[0];
        REG_BASE_LEVEL:   base_level_r   <= level_t'(cfg_pwdata[LEVEL_W-1:0]);
        REG_REF_CORR:     ref_corr_r     <= level_t'(cfg_pwdata[LEVEL_W-1:0]);
        REG_MAX_LEVEL:    max_level_r    <= level_t'(cfg_pwdata[LEVEL_W-1:0]);
        REG_MIN_LEVEL:    min_level_r    <= level_t'(cfg_pwdata[LEVEL_W-1:0]);
        REG_TABLE_LENGTH: table_length_r <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_USE_TABLE:    cfg_prdata = CFG_DATA_W'(use_table_r);
      REG_BASE_LEVEL:   cfg_prdata = CFG_DATA_W'(base_level_r);
      REG_REF_CORR:     cfg_prdata = CFG_DATA_W'(ref_corr_r);
      REG_MAX_LEVEL:    cfg_prdata = CFG_DATA_W'(max_level_r);
      REG_MIN_LEVEL:    cfg_prdata = CFG_DATA_W'(min_level_r);
      REG_TABLE_LENGTH: cfg_prdata = CFG_DATA_W'(table_length_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- table length and bracket arithmetic
  assign len_x = LEN_X_W'(table_length_r);
  always_comb begin
    if (len_x < LEN_X_W'(2)) used_len = LEN_X_W'(2);
    else if (len_x > LEN_X_W'(TABLE_DEPTH)) used_len = LEN_X_W'(TABLE_DEPTH);
    else used_len = len_x;
  end
  assign last_idx = IDX_W'(used_len - LEN_X_W'(1));
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[IDX_W:1];
  assign span     = hi_r - lo_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_ok     = (LEN_X_W'(in_ch.entry_index) < LEN_X_W'(TABLE_DEPTH));
  assign tbl_wr      = in_acc && (in_ch.kind == KIND_LOAD) && load_ok;

  always_comb begin
    unique case (state_r)
      S_RD_LO: rd_addr = last_idx;
      S_BIS:   rd_addr = mid;
      default: rd_addr = '0;
    endcase
  end

  ctli_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FREQ_BITS   (FREQ_BITS),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (IDX_W'(in_ch.entry_index)),
    .wr_freq (in_ch.frequency_hz),
    .wr_corr (in_ch.entry_correction),
    .rd_addr (rd_addr),
    .rd_freq (rd_freq),
    .rd_corr (rd_corr)
  );

  ctli_mdu #(
    .FREQ_BITS (FREQ_BITS)
  ) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mdu_start),
    .c_lo  (c_lo_r),
    .c_hi  (c_hi_r),
    .num   (f_q_r - f_lo_r),
    .den   (f_hi_r - f_lo_r),
    .done  (mdu_done),
    .q     (mdu_q)
  );

  // ---------------- level and clamps (lower clamp first)
  assign lvl_raw = sum_t'(base_level_r) + sum_t'(corr_r) - sum_t'(ref_corr_r);
  assign hit_lo  = (lvl_raw < sum_t'(min_level_r));
  assign lvl_lo  = hit_lo ? sum_t'(min_level_r) : lvl_raw;
  assign hit_hi  = (lvl_lo > sum_t'(max_level_r));
  assign lvl_fin = hit_hi ? sum_t'(max_level_r) : lvl_lo;

  // ---------------- sequencer
  always_comb begin
    state_nxt       = state_r;
    f_q_nxt         = f_q_r;
    f_lo_nxt        = f_lo_r;
    f_hi_nxt        = f_hi_r;
    c_lo_nxt        = c_lo_r;
    c_hi_nxt        = c_hi_r;
    corr_nxt        = corr_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    oot_nxt         = oot_r;
    byp_nxt         = byp_r;
    mdu_start       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_level_nxt   = out_level_r;
    out_clamped_nxt = out_clamped_r;
    out_oot_nxt     = out_oot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.kind == KIND_QUERY)) begin
          f_q_nxt = in_ch.frequency_hz;
          oot_nxt = 1'b0;
          lo_nxt  = '0;
          if (use_table_r) begin
            byp_nxt   = 1'b0;
            state_nxt = S_RD_LO;
          end else begin
            byp_nxt   = 1'b1;
            state_nxt = S_SUM;
          end
        end
      end
      S_RD_LO: begin
        f_lo_nxt  = rd_freq;
        c_lo_nxt  = rd_corr;
        hi_nxt    = last_idx;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        f_hi_nxt = rd_freq;
        c_hi_nxt = rd_corr;
        priority if (f_q_r < f_lo_r) begin
          corr_nxt  = c_lo_r;
          oot_nxt   = 1'b1;
          state_nxt = S_SUM;
        end else if (f_q_r > rd_freq) begin
          corr_nxt  = rd_corr;
          oot_nxt   = 1'b1;
          state_nxt = S_SUM;
        end else if (f_q_r == f_lo_r) begin
          corr_nxt  = c_lo_r;
          state_nxt = S_SUM;
        end else if (f_q_r == rd_freq) begin
          corr_nxt  = rd_corr;
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_BIS;
        end
      end
      S_BIS: begin
        // mid read issued here; S_MID uses it when the bracket is still wide
        if (span > IDX_W'(1)) state_nxt = S_MID;
        else state_nxt = S_END;
      end
      S_MID: begin
        if (f_q_r > rd_freq) begin
          lo_nxt   = mid;
          f_lo_nxt = rd_freq;
          c_lo_nxt = rd_corr;
        end else begin
          hi_nxt   = mid;
          f_hi_nxt = rd_freq;
          c_hi_nxt = rd_corr;
        end
        state_nxt = S_BIS;
      end
      S_END: begin
        priority if (f_q_r <= f_lo_r) begin
          corr_nxt  = c_lo_r;
          state_nxt = S_SUM;
        end else if (f_q_r >= f_hi_r) begin
          corr_nxt  = c_hi_r;
          state_nxt = S_SUM;
        end else begin
          mdu_start = 1'b1;
          state_nxt = S_MDU;
        end
      end
      S_MDU: begin
        if (mdu_done) begin
          corr_nxt  = mdu_q;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (byp_r) begin
            out_level_nxt   = base_level_r;
            out_clamped_nxt = 1'b0;
            out_oot_nxt     = 1'b0;
          end else begin
            out_level_nxt   = level_t'(lvl_fin[LEVEL_W-1:0]);
            out_clamped_nxt = hit_lo || hit_hi;
            out_oot_nxt     = oot_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_q_r         <= f_q_nxt;
    f_lo_r        <= f_lo_nxt;
    f_hi_r        <= f_hi_nxt;
    c_lo_r        <= c_lo_nxt;
    c_hi_r        <= c_hi_nxt;
    corr_r        <= corr_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    oot_r         <= oot_nxt;
    byp_r         <= byp_nxt;
    out_level_r   <= out_level_nxt;
    out_clamped_r <= out_clamped_nxt;
    out_oot_r     <= out_oot_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.level        = out_level_r;
  assign out_ch.clamped      = out_clamped_r;
  assign out_ch.out_of_table = out_oot_r;

  // ---------------- assertions
  a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BIS || state_r == S_MID) |-> (lo_r < hi_r))
    else $error("bisection bracket collapsed");

  a_one_side_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MID) |=> ((lo_r != $past(lo_r)) != (hi_r != $past(hi_r))))
    else $error("bisection step must move exactly one bracket end");

  a_mdu_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_done |-> (state_r == S_MDU))
    else $error("mul/div result with no waiting query");

endmodule

// ===== sv/ctli_table.sv =====
module ctli_table
  import ctli_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int FREQ_BITS   = DEF_FREQ_BITS,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [FREQ_BITS-1:0] wr_freq,
  input  level_t               wr_corr,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [FREQ_BITS-1:0] rd_freq,
  output level_t               rd_corr
);

  logic [FREQ_BITS-1:0] freq_mem [TABLE_DEPTH];
  level_t               corr_mem [TABLE_DEPTH];
  logic [FREQ_BITS-1:0] rd_freq_r;
  level_t               rd_corr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem[wr_addr] <= wr_freq;
      corr_mem[wr_addr] <= wr_corr;
    end
    rd_freq_r <= freq_mem[rd_addr];
    rd_corr_r <= corr_mem[rd_addr];
  end

  assign rd_freq = rd_freq_r;
  assign rd_corr = rd_corr_r;

endmodule

// ===== sv/ctli_mdu.sv =====
// Iterative multiply/divide around one shared adder.
// total = c_lo*(den-num) + c_hi*num, MSB-first shift-add over the 12 bits of both
// corrections; then |total| / den restoring, round half away from zero, restore sign.
module ctli_mdu
  import ctli_pkg::*;
#(
  parameter int FREQ_BITS = DEF_FREQ_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  level_t               c_lo,
  input  level_t               c_hi,
  input  logic [FREQ_BITS-1:0] num,
  input  logic [FREQ_BITS-1:0] den,
  output logic                 done,
  output level_t               q
);

  localparam int W   = FREQ_BITS + LEVEL_W + 1;
  localparam int Q_W = LEVEL_W + 1;
  localparam logic [3:0] MSB_STEP = 4'(LEVEL_W - 1);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_MUL  = 3'd1;
  localparam logic [2:0] M_ABS  = 3'd2;
  localparam logic [2:0] M_DIV  = 3'd3;
  localparam logic [2:0] M_RND  = 3'd4;
  localparam logic [2:0] M_NEG  = 3'd5;
  localparam logic [2:0] M_DONE = 3'd6;

  logic [2:0]           st_r, st_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [W-1:0]         acc_r, acc_nxt;
  logic [FREQ_BITS-1:0] a_r, a_nxt;
  logic [FREQ_BITS-1:0] num_r, num_nxt;
  logic [FREQ_BITS-1:0] den_r, den_nxt;
  level_t               clo_r, clo_nxt;
  level_t               chi_r, chi_nxt;
  logic                 neg_r, neg_nxt;
  logic [Q_W-1:0]       q_r, q_nxt;

  // shared adder
  logic [W-1:0] op_a, op_b, sum, sel;
  logic         sub;

  assign sum = op_a + (sub ? ~op_b : op_b) + W'(sub);

  // both bits set: (den - num) + num = den
  always_comb begin
    unique case ({clo_r[cnt_r], chi_r[cnt_r]})
      2'b00:   sel = '0;
      2'b10:   sel = W'(a_r);
      2'b01:   sel = W'(num_r);
      default: sel = W'(den_r);
    endcase
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    a_nxt   = a_r;
    num_nxt = num_r;
    den_nxt = den_r;
    clo_nxt = clo_r;
    chi_nxt = chi_r;
    neg_nxt = neg_r;
    q_nxt   = q_r;
    op_a    = '0;
    op_b    = '0;
    sub     = 1'b0;
    unique case (st_r)
      M_IDLE: begin
        op_a = W'(den);
        op_b = W'(num);
        sub  = 1'b1;
        if (start) begin
          a_nxt   = sum[FREQ_BITS-1:0];
          num_nxt = num;
          den_nxt = den;
          clo_nxt = c_lo;
          chi_nxt = c_hi;
          cnt_nxt = MSB_STEP;
          st_nxt  = M_MUL;
        end
      end
      M_MUL: begin
        // sign bit carries negative weight
        op_a    = (cnt_r == MSB_STEP) ? '0 : (acc_r << 1);
        op_b    = sel;
        sub     = (cnt_r == MSB_STEP);
        acc_nxt = sum;
        if (cnt_r == 4'd0) st_nxt = M_ABS;
        else cnt_nxt = cnt_r - 4'd1;
      end
      M_ABS: begin
        op_a    = '0;
        op_b    = acc_r;
        sub     = 1'b1;
        neg_nxt = acc_r[W-1];
        if (acc_r[W-1]) acc_nxt = sum;
        q_nxt   = '0;
        cnt_nxt = MSB_STEP;
        st_nxt  = M_DIV;
      end
      M_DIV: begin
        op_a = acc_r;
        op_b = W'(den_r) << cnt_r;
        sub  = 1'b1;
        if (!sum[W-1]) begin
          acc_nxt      = sum;
          q_nxt[cnt_r] = 1'b1;
        end
        if (cnt_r == 4'd0) st_nxt = M_RND;
        else cnt_nxt = cnt_r - 4'd1;
      end
      M_RND: begin
        // 2*rem >= den rounds up
        op_a = acc_r << 1;
        op_b = W'(den_r);
        sub  = 1'b1;
        if (!sum[W-1]) q_nxt = q_r + Q_W'(1);
        st_nxt = M_NEG;
      end
      M_NEG: begin
        op_a   = '0;
        op_b   = W'(q_r);
        sub    = neg_r;
        q_nxt  = sum[Q_W-1:0];
        st_nxt = M_DONE;
      end
      M_DONE: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    clo_r <= clo_nxt;
    chi_r <= chi_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign done = (st_r == M_DONE);
  assign q    = level_t'(q_r[LEVEL_W-1:0]);

endmodule
